/* rtl/core/bm25atk_pkg.sv */
// ----------------------------------------------------------------------------
// BM25 top-K package
// Shared types and constants of the BM25 score accumulator with top-K ranking.
// ----------------------------------------------------------------------------
package bm25atk_pkg;

    typedef enum logic [1:0] {
        ACT_START  = 2'd0,
        ACT_POST   = 2'd1,
        ACT_FINISH = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        CFG_K1     = 2'd0,
        CFG_B      = 2'd1,
        CFG_AVGDL  = 2'd2,
        CFG_TOP_K  = 2'd3
    } cfg_index_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PREP,
        ST_DIV1,
        ST_NORM,
        ST_MUL,
        ST_DIV2,
        ST_SCALE,
        ST_WRITE,
        ST_WALK,
        ST_EMIT
    } state_t;

    localparam int SCORE_W  = 32;
    localparam int DOC_W    = 10;
    localparam int DIV_W    = 64;
    localparam int DIVCNT_W = 6;
    localparam int RATIO_W  = 21;
    localparam int NORM_W   = 38;
    localparam logic [12:0] B_ONE = 13'd4096;

endpackage

/* rtl/core/bm25atk_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// Simple dual-port synchronous RAM with a registered read port.
// ----------------------------------------------------------------------------
module bm25atk_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 1024
) (
    input  logic                                   aclk,
    input  logic                                   wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule

/* rtl/core/bm25_accumulate_top_k_core.sv */
// ----------------------------------------------------------------------------
// BM25 accumulate top-K core
// Posting: two 64-step serial divisions, the first skipped without length norm.
// Start: a sweep that clears the score RAM; finish: a walk of the score RAM,
// then one result beat per cycle as the sink takes them.
// One item at a time; the RAM sweeps and the shared serial divider set the pace.
// Reset (aresetn low, synchronous) restores control and config registers and starts a clear sweep.
// ----------------------------------------------------------------------------
module bm25_accumulate_top_k_core #(
    parameter int MAX_DOCS = 1024,
    parameter int MAX_K    = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_action,
    input  logic [9:0]  s_doc_id,
    input  logic [15:0] s_term_freq,
    input  logic [15:0] s_doc_length,
    input  logic [31:0] s_term_idf,
    input  logic        s_in_candidates,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [9:0]  m_result_doc,
    output logic [31:0] m_result_score,
    output logic        m_last_result,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_data
);
    import bm25atk_pkg::*;

    localparam int AW = MAX_DOCS > 1 ? $clog2(MAX_DOCS) : 1;
    localparam int CW = AW + 1;
    localparam int KW = $clog2(MAX_K + 1);
    localparam int IW = MAX_K > 1 ? $clog2(MAX_K) : 1;

    state_t state_reg, state_next;

    logic [15:0] k1_reg;
    logic [12:0] b_reg;
    logic [23:0] avgdl_reg;
    logic [4:0]  topk_reg;

    logic [AW-1:0]      post_addr_reg;
    logic [15:0]        tf_reg, len_reg;
    logic [31:0]        idf_reg;
    logic [SCORE_W-1:0] old_reg, add_reg;
    logic [NORM_W-1:0]  norm_reg;
    logic [CW-1:0]      cnt_reg;
    logic               pend_reg;
    logic [AW-1:0]      pend_addr_reg;

    logic [DIV_W-1:0]    dvd_reg, dvs_reg, rem_reg, quo_reg;
    logic [DIVCNT_W-1:0] dcnt_reg;

    logic [SCORE_W-1:0] best_s_reg [MAX_K];
    logic [DOC_W-1:0]   best_d_reg [MAX_K];
    logic [KW-1:0]      count_reg;
    logic [IW-1:0]      emit_reg;

    logic              ram_we, ram_re;
    logic [AW-1:0]     ram_waddr, ram_raddr;
    logic [SCORE_W:0]  ram_wdata, ram_rdata;

    bm25atk_ram #(.WIDTH(SCORE_W + 1), .DEPTH(MAX_DOCS)) u_score_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // Input decode.
    logic s_acc, post_ok, doc_in_range;
    assign s_acc        = s_valid && s_ready;
    assign doc_in_range = 32'(s_doc_id) < MAX_DOCS;
    assign post_ok      = (s_action == ACT_POST) && s_in_candidates && doc_in_range;

    logic [12:0] b_sat;
    assign b_sat = (b_reg > B_ONE) ? B_ONE : b_reg;

    logic [KW-1:0] k_eff;
    assign k_eff = (32'(topk_reg) > MAX_K) ? KW'(MAX_K) : KW'(topk_reg);

    // Restoring divider step, one quotient bit per cycle.
    logic [DIV_W:0]   div_sh;
    logic             div_ge;
    logic [DIV_W-1:0] div_rem_next;
    assign div_sh       = {rem_reg, dvd_reg[DIV_W-1]};
    assign div_ge       = div_sh >= {1'b0, dvs_reg};
    assign div_rem_next = div_ge ? DIV_W'(div_sh - {1'b0, dvs_reg}) : div_sh[DIV_W-1:0];

    // Arithmetic feeding the divider loads.
    logic [28:0] blen;
    logic [16:0] k1p;
    logic [32:0] num;
    logic [53:0] kn;
    logic [DIV_W-1:0] den;
    assign blen = 29'(b_sat * len_reg);
    assign k1p  = 17'(k1_reg) + 17'd4096;
    assign num  = 33'(tf_reg * k1p);
    assign kn   = 54'(k1_reg * norm_reg);
    assign den  = {24'd0, tf_reg, 24'd0} + DIV_W'(kn);

    logic [52:0] scaled_prod;
    logic [36:0] scaled;
    assign scaled_prod = 53'(idf_reg * quo_reg[RATIO_W-1:0]);
    assign scaled      = scaled_prod[52:16];

    logic [SCORE_W:0] sum;
    assign sum = {1'b0, old_reg} + {1'b0, add_reg};

    // Ranking insert: slots holding a score at or above the new one stay put.
    logic [MAX_K-1:0] ge;
    logic             ins_ok, ins_do;
    always_comb begin
        for (int i = 0; i < MAX_K; i++) begin
            ge[i] = (KW'(i) < count_reg) && (best_s_reg[i] >= ram_rdata[SCORE_W-1:0]);
        end
    end
    assign ins_ok = !ge[IW'(k_eff - KW'(1))];
    assign ins_do = (state_reg == ST_WALK) && pend_reg && ram_rdata[SCORE_W] && ins_ok;

    logic walk_done;
    assign walk_done = (cnt_reg == CW'(MAX_DOCS)) && !pend_reg;

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (cnt_reg == CW'(MAX_DOCS - 1)) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_acc) begin
                    case (s_action)
                        ACT_START:  state_next = ST_CLEAR;
                        ACT_POST:   state_next = post_ok ? ST_PREP : ST_IDLE;
                        ACT_FINISH: state_next = (k_eff != '0) ? ST_WALK : ST_IDLE;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_PREP:  state_next = (avgdl_reg != '0) ? ST_DIV1 : ST_NORM;
            ST_DIV1: begin
                if (dcnt_reg == '1) state_next = ST_NORM;
            end
            ST_NORM:  state_next = ST_MUL;
            ST_MUL:   state_next = ST_DIV2;
            ST_DIV2: begin
                if (dcnt_reg == '1) state_next = ST_SCALE;
            end
            ST_SCALE: state_next = ST_WRITE;
            ST_WRITE: state_next = ST_IDLE;
            ST_WALK: begin
                if (walk_done) state_next = (count_reg != '0) ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT: begin
                if (m_ready && m_last_result) state_next = ST_IDLE;
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // Outputs and RAM control.
    always_comb begin
        s_ready   = 1'b0;
        m_valid   = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = post_addr_reg;
        ram_wdata = {1'b1, sum[SCORE_W] ? {SCORE_W{1'b1}} : sum[SCORE_W-1:0]};
        ram_re    = 1'b0;
        ram_raddr = AW'(s_doc_id);
        case (state_reg)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = cnt_reg[AW-1:0];
                ram_wdata = '0;
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                ram_re  = s_valid && post_ok;
            end
            ST_WRITE: ram_we = 1'b1;
            ST_WALK: begin
                ram_re    = cnt_reg != CW'(MAX_DOCS);
                ram_raddr = cnt_reg[AW-1:0];
            end
            ST_EMIT:  m_valid = 1'b1;
            default: begin
            end
        endcase
    end

    assign m_result_doc   = best_d_reg[emit_reg];
    assign m_result_score = best_s_reg[emit_reg];
    assign m_last_result  = (KW'(emit_reg) + KW'(1)) == count_reg;
    assign cfg_ready      = 1'b1;

    // Control and configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            cnt_reg   <= '0;
            pend_reg  <= 1'b0;
            count_reg <= '0;
            emit_reg  <= '0;
            dcnt_reg  <= '0;
            k1_reg    <= 16'd4915;
            b_reg     <= 13'd3072;
            avgdl_reg <= '0;
            topk_reg  <= 5'd10;
        end else begin
            state_reg <= state_next;
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_K1:    k1_reg    <= cfg_data[15:0];
                    CFG_B:     b_reg     <= cfg_data[12:0];
                    CFG_AVGDL: avgdl_reg <= cfg_data;
                    CFG_TOP_K: topk_reg  <= cfg_data[4:0];
                    default: begin
                    end
                endcase
            end
            case (state_reg)
                ST_CLEAR: cnt_reg <= cnt_reg + CW'(1);
                ST_IDLE: begin
                    cnt_reg  <= '0;
                    emit_reg <= '0;
                    dcnt_reg <= '0;
                    if (s_acc && s_action == ACT_FINISH) count_reg <= '0;
                end
                ST_DIV1, ST_DIV2: dcnt_reg <= dcnt_reg + DIVCNT_W'(1);
                ST_WALK: begin
                    pend_reg <= ram_re;
                    if (ram_re) cnt_reg <= cnt_reg + CW'(1);
                    if (ins_do && count_reg < k_eff) count_reg <= count_reg + KW'(1);
                end
                ST_EMIT: begin
                    if (m_ready) emit_reg <= emit_reg + IW'(1);
                end
                default: begin
                end
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && s_acc) begin
            post_addr_reg <= AW'(s_doc_id);
            tf_reg        <= s_term_freq;
            len_reg       <= s_doc_length;
            idf_reg       <= s_term_idf;
        end
        pend_addr_reg <= cnt_reg[AW-1:0];
        case (state_reg)
            ST_PREP: begin
                old_reg <= ram_rdata[SCORE_W-1:0];
                dvd_reg <= {27'd0, blen, 8'd0};
                dvs_reg <= DIV_W'(avgdl_reg);
                rem_reg <= '0;
                quo_reg <= '0;
            end
            ST_DIV1, ST_DIV2: begin
                dvd_reg <= {dvd_reg[DIV_W-2:0], 1'b0};
                rem_reg <= div_rem_next;
                quo_reg <= {quo_reg[DIV_W-2:0], div_ge};
            end
            ST_NORM: begin
                if (avgdl_reg != '0) begin
                    norm_reg <= NORM_W'(4096) - NORM_W'(b_sat) + NORM_W'(quo_reg[36:0]);
                end else begin
                    norm_reg <= NORM_W'(4096);
                end
            end
            ST_MUL: begin
                dvd_reg <= {3'd0, num, 28'd0};
                dvs_reg <= den;
                rem_reg <= '0;
                quo_reg <= '0;
            end
            ST_SCALE: begin
                if (tf_reg == '0) begin
                    add_reg <= '0;
                end else if (|scaled[36:32]) begin
                    add_reg <= '1;
                end else begin
                    add_reg <= scaled[31:0];
                end
            end
            default: begin
            end
        endcase
        if (ins_do) begin
            for (int i = 0; i < MAX_K; i++) begin
                if (!ge[i]) begin
                    if (i == 0 || ge[(i == 0) ? 0 : i - 1]) begin
                        best_s_reg[i] <= ram_rdata[SCORE_W-1:0];
                        best_d_reg[i] <= DOC_W'(pend_addr_reg);
                    end else begin
                        best_s_reg[i] <= best_s_reg[(i == 0) ? 0 : i - 1];
                        best_d_reg[i] <= best_d_reg[(i == 0) ? 0 : i - 1];
                    end
                end
            end
        end
    end
endmodule

/* dv/tb_bm25_accumulate_top_k_core.sv */
// ----------------------------------------------------------------------------
// BM25 accumulate top-K core testbench
// Drives start, posting and finish beats with random gaps and back-pressure,
// predicts the ranked results of every finish, and compares each result beat.
// ----------------------------------------------------------------------------
module tb_bm25_accumulate_top_k_core;
    timeunit 1ns;
    timeprecision 1ps;
    import bm25atk_pkg::*;

    localparam int NUM_DOCS    = 1024;
    localparam int RANK_MAX    = 16;
    localparam int IDLE_CYCLES = 1200;
    localparam int STALL_LIMIT = 20000;

    typedef struct packed {
        logic [9:0]  doc;
        logic [31:0] score;
        logic        last;
    } ranked_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_action;
    logic [9:0]  s_doc_id;
    logic [15:0] s_term_freq;
    logic [15:0] s_doc_length;
    logic [31:0] s_term_idf;
    logic        s_in_candidates;
    logic        m_valid;
    logic        m_ready;
    logic [9:0]  m_result_doc;
    logic [31:0] m_result_score;
    logic        m_last_result;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [23:0] cfg_data;

    // Predictor state.
    logic [15:0] k1_q;
    logic [12:0] b_q;
    logic [23:0] avgdl_q;
    logic [4:0]  top_k_q;
    logic [31:0] doc_score[NUM_DOCS];
    bit          doc_touched[NUM_DOCS];

    ranked_t ranking_q[$];
    int      mismatches = 0;
    int      items_sent;
    int      quiet_cycles = 0;
    int      sink_wait;
    bit      no_idle;

    bm25_accumulate_top_k_core u_top (.*);

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    function automatic logic [31:0] bm25_term(logic [15:0] tf, logic [15:0] len,
                                              logic [31:0] idf);
        logic [63:0] b;
        logic [63:0] norm;
        logic [63:0] den;
        logic [63:0] ratio;
        logic [63:0] add;
        b = (b_q > B_ONE) ? 64'd4096 : 64'(b_q);
        norm = 64'd4096;
        if (tf == 16'd0) begin
            return 32'd0;
        end
        if (avgdl_q != 24'd0) begin
            norm = 64'd4096 - b + (b * 64'(len) * 64'd256) / 64'(avgdl_q);
        end
        den = (64'(tf) << 24) + 64'(k1_q) * norm;
        ratio = ((64'(tf) * (64'(k1_q) + 64'd4096)) << 28) / den;
        add = (64'(idf) * ratio) >> 16;
        return (add > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : add[31:0];
    endfunction

    function automatic void predict_beat(action_t act, logic [9:0] doc, logic [15:0] tf,
                                         logic [15:0] len, logic [31:0] idf, logic cand);
        logic [32:0] sum;
        logic [31:0] best_s[RANK_MAX];
        logic [9:0]  best_d[RANK_MAX];
        int k;
        int cnt;
        int pos;
        ranked_t r;
        case (act)
            ACT_START: begin
                for (int d = 0; d < NUM_DOCS; d++) begin
                    doc_score[d] = '0;
                    doc_touched[d] = 0;
                end
            end
            ACT_POST: begin
                if (cand) begin
                    sum = 33'(doc_score[doc]) + 33'(bm25_term(tf, len, idf));
                    doc_score[doc] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                    doc_touched[doc] = 1;
                end
            end
            ACT_FINISH: begin
                k = (top_k_q > RANK_MAX) ? RANK_MAX : int'(top_k_q);
                cnt = 0;
                // Ascending id walk that steps past equal scores keeps lower ids ahead on ties.
                for (int d = 0; d < NUM_DOCS; d++) begin
                    if (doc_touched[d] && k > 0) begin
                        pos = 0;
                        while (pos < cnt && best_s[pos] >= doc_score[d]) pos++;
                        if (pos < k) begin
                            for (int i = (cnt < k ? cnt : k - 1); i > pos; i--) begin
                                best_s[i] = best_s[i-1];
                                best_d[i] = best_d[i-1];
                            end
                            best_s[pos] = doc_score[d];
                            best_d[pos] = 10'(d);
                            if (cnt < k) cnt++;
                        end
                    end
                end
                for (int i = 0; i < cnt; i++) begin
                    r.doc = best_d[i];
                    r.score = best_s[i];
                    r.last = (i == cnt - 1);
                    ranking_q.insert(ranking_q.size(), r);
                end
            end
            default: ;
        endcase
    endfunction

    task automatic send_beat(action_t act, logic [9:0] doc, logic [15:0] tf,
                             logic [15:0] len, logic [31:0] idf, logic cand);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_action <= act;
        s_doc_id <= doc;
        s_term_freq <= tf;
        s_doc_length <= len;
        s_term_idf <= idf;
        s_in_candidates <= cand;
        do @(posedge aclk); while (!s_ready);
        predict_beat(act, doc, tf, len, idf, cand);
        items_sent++;
    endtask

    task automatic post(logic [9:0] doc, logic [15:0] tf, logic [15:0] len, logic [31:0] idf);
        send_beat(ACT_POST, doc, tf, len, idf, 1'b1);
    endtask

    task automatic send_cmd(action_t act);
        send_beat(act, 10'($urandom), 16'($urandom), 16'($urandom), 32'($urandom),
                  1'($urandom));
    endtask

    // Lets every outstanding result drain and the last posting finish in the core.
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (ranking_q.size() != 0) @(posedge aclk);
        repeat (IDLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [23:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_K1:    k1_q = data[15:0];
            CFG_B:     b_q = data[12:0];
            CFG_AVGDL: avgdl_q = data;
            CFG_TOP_K: top_k_q = data[4:0];
            default: ;
        endcase
    endtask

    task automatic test_post_before_start();
        post(10'd5, 16'd3, 16'd100, 32'h0001_0000);
        post(10'd6, 16'd1, 16'd0, 32'h0000_8000);
        send_cmd(ACT_FINISH);
    endtask

    task automatic test_special_cases();
        wait_idle();
        write_reg(CFG_K1, 24'hFFFF);
        write_reg(CFG_B, 24'h1FFF);
        write_reg(CFG_AVGDL, 24'd100 << 8);
        write_reg(CFG_TOP_K, 24'd31);
        send_cmd(ACT_START);
        post(10'd7, 16'd0, 16'd50, 32'h0002_0000);
        send_beat(ACT_POST, 10'd8, 16'd4, 16'd50, 32'h0002_0000, 1'b0);
        send_beat(ACT_NONE, 10'd9, 16'd4, 16'd50, 32'h0002_0000, 1'b1);
        post(10'd1023, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
        post(10'd1023, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
        post(10'd0, 16'd1, 16'd0, 32'h0001_0000);
        post(10'd2, 16'd1, 16'd0, 32'h0001_0000);
        send_cmd(ACT_FINISH);
        send_cmd(ACT_FINISH);
        wait_idle();
        write_reg(CFG_TOP_K, 24'd0);
        send_cmd(ACT_FINISH);
        wait_idle();
        write_reg(CFG_TOP_K, 24'd16);
        write_reg(CFG_K1, 24'd0);
        write_reg(CFG_B, 24'd0);
        write_reg(CFG_AVGDL, 24'd1);
        send_cmd(ACT_START);
        send_cmd(ACT_FINISH);
        post(10'd3, 16'd1, 16'hFFFF, 32'h0000_0001);
        send_cmd(ACT_FINISH);
        wait_idle();
        write_reg(CFG_K1, 24'd4915);
        write_reg(CFG_B, 24'd4096);
        write_reg(CFG_AVGDL, 24'hFFFFFF);
        send_cmd(ACT_START);
        post(10'd4, 16'd2, 16'd0, 32'h0003_0000);
        send_cmd(ACT_FINISH);
    endtask

    task automatic test_random_queries();
        int n;
        logic [9:0]  doc;
        logic [15:0] tf;
        logic [15:0] len;
        logic [31:0] idf;
        while (items_sent < 165) begin
            no_idle = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 1)) begin
                wait_idle();
                write_reg(CFG_K1, $urandom_range(0, 3) == 0 ? 24'(16'($urandom))
                                                          : 24'($urandom_range(1000, 9000)));
                write_reg(CFG_B, $urandom_range(0, 4) == 0 ? 24'(13'($urandom))
                                                         : 24'($urandom_range(0, 4096)));
                case ($urandom_range(0, 3))
                    0: write_reg(CFG_AVGDL, 24'd0);
                    1: write_reg(CFG_AVGDL, 24'($urandom));
                    default: write_reg(CFG_AVGDL, 24'($urandom_range(256, 200 << 8)));
                endcase
                write_reg(CFG_TOP_K, 24'($urandom_range(0, 31)));
            end
            send_cmd(ACT_START);
            n = $urandom_range(4, 20);
            repeat (n) begin
                doc = ($urandom_range(0, 4) == 0) ? 10'($urandom) : 10'($urandom_range(0, 24));
                tf  = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 20));
                len = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 400));
                idf = ($urandom_range(0, 4) == 0) ? 32'($urandom)
                                                  : 32'($urandom_range(0, 32'h8_0000));
                case ($urandom_range(0, 9))
                    0: send_beat(ACT_POST, doc, tf, len, idf, 1'b0);
                    1: send_beat(action_t'($urandom_range(0, 3)), doc, tf, len, idf,
                                 1'($urandom));
                    default: post(doc, tf, len, idf);
                endcase
            end
            send_cmd(ACT_FINISH);
        end
    endtask

    // Result sink: a stall of random length before each beat unless no_idle is set.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            sink_wait <= 0;
        end else if (m_valid && m_ready) begin
            sink_wait <= no_idle ? 0 : $urandom_range(0, 4);
            m_ready <= no_idle || ($urandom_range(0, 4) == 0);
        end else if (sink_wait > 0) begin
            sink_wait <= sink_wait - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        ranked_t want;
        if (aresetn && m_valid && m_ready) begin
            if (ranking_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: doc %0d score %h last %0b",
                             m_result_doc, m_result_score, m_last_result);
            end else begin
                want = ranking_q.pop_front();
                if (m_result_doc !== want.doc || m_result_score !== want.score ||
                    m_last_result !== want.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result beat: exp %0d %h %0b, got %0d %h %0b",
                                 want.doc, want.score, want.last,
                                 m_result_doc, m_result_score, m_last_result);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == STALL_LIMIT) begin
            $display("bm25_accumulate_top_k_core: mismatch");
            $finish;
        end
    end

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_action = ACT_START;
        s_doc_id = '0;
        s_term_freq = '0;
        s_doc_length = '0;
        s_term_idf = '0;
        s_in_candidates = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_K1;
        cfg_data = '0;
        items_sent = 0;
        no_idle = 0;
        k1_q = 16'd4915;
        b_q = 13'd3072;
        avgdl_q = '0;
        top_k_q = 5'd10;
        for (int d = 0; d < NUM_DOCS; d++) begin
            doc_score[d] = '0;
            doc_touched[d] = 0;
        end
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        test_post_before_start();
        test_special_cases();
        test_random_queries();
        s_valid <= 1'b0;
        while (ranking_q.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (mismatches == 0 && ranking_q.size() == 0)
            $display("bm25_accumulate_top_k_core: match");
        else
            $display("bm25_accumulate_top_k_core: mismatch");
        $finish;
    end

endmodule

/* bm25_accumulate_top_k_core.f */
rtl/core/bm25atk_pkg.sv
rtl/core/bm25atk_ram.sv
rtl/core/bm25_accumulate_top_k_core.sv
dv/tb_bm25_accumulate_top_k_core.sv
